// ===== rtl/tags_pkg.sv =====
// ----------------------------------------------------------------------------
// tags_pkg
// Shared types and constants of the time-aware gate scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tags_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int NUM_QUEUES_DEF  = 8;

    localparam int TW      = 48;       // time field width
    localparam int SW      = 50;       // internal schedule arithmetic width
    localparam int DW      = 32;       // duration and guard width
    localparam int MW      = 8;        // gate mask width
    localparam int QW      = 3;        // queue index width
    localparam int ENTRY_W = 3 * DW + MW;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_DECIDE = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_EV,
        S_MOD,
        S_CINIT,
        S_CHS_RD,
        S_CHS_EV,
        S_WAIT_RD,
        S_WAIT_EV,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SUM,
        DP_MOD_INIT,
        DP_MOD_STEP,
        DP_PASS_INIT,
        DP_CHS,
        DP_WAIT,
        DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic ne_zero;
        logic len_zero;
        logic chosen_valid;
        logic chs_hit;
        logic wait_hit;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/tags_ram.sv =====
// ----------------------------------------------------------------------------
// tags_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tags_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]              i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tags_dp.sv =====
// ----------------------------------------------------------------------------
// tags_dp
// Datapath: cycle length sum, bit-serial modulo, queue choice and wait walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tags_dp
    import tags_pkg::*;
#(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [TW-1:0]      i_now_time,
    input  wire logic [MW-1:0]      i_nonempty_mask,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_queue_found,
    output logic [QW-1:0]           o_chosen_queue,
    output logic                    o_dequeue_now,
    output logic [TW-1:0]           o_wait_time
);

    localparam logic [MW-1:0] QMASK = MW'((1 << NUM_QUEUES) - 1);

    logic [TW-1:0] r_now;
    logic [MW-1:0] r_ne;
    logic [SW-1:0] r_len, r_rem, r_off, r_lmt, r_open, r_wrap;
    logic [QW-1:0] r_chosen;
    logic          r_chosen_valid, r_chs_hit, r_wait_hit, r_any_seen, r_j_seen;

    logic [DW-1:0] w_dur, w_sg, w_stg;
    logic [MW-1:0] w_mask, w_cand, w_has_q;
    logic [SW-1:0] w_end, w_open, w_rem_sh, w_t_stop;
    logic          w_cand_any;
    logic [QW-1:0] w_cand_hi, w_ne_lo;

    assign w_dur  = i_entry[DW-1:0];
    assign w_mask = i_entry[DW +: MW];
    assign w_sg   = i_entry[DW + MW +: DW];
    assign w_stg  = i_entry[2*DW + MW +: DW];

    assign w_end    = r_off + SW'(w_dur);
    assign w_open   = r_off + SW'(w_sg);
    assign w_t_stop = r_rem + SW'(w_stg);
    assign w_rem_sh = {r_rem[SW-2:0], r_now[TW-1]};
    assign w_cand   = w_mask & r_ne;
    assign w_cand_any = |w_cand;
    assign w_has_q  = w_mask >> r_chosen;

    always_comb begin
        w_cand_hi = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (w_cand[q]) begin
                w_cand_hi = QW'(q);
            end
        end
        w_ne_lo = '0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
            if (r_ne[q]) begin
                w_ne_lo = QW'(q);
            end
        end
    end

    assign o_stat = '{
        ne_zero:      (r_ne == '0),
        len_zero:     (r_len == '0),
        chosen_valid: r_chosen_valid,
        chs_hit:      r_chs_hit,
        wait_hit:     r_wait_hit
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chosen_valid <= 1'b0;
            r_chs_hit      <= 1'b0;
            r_wait_hit     <= 1'b0;
            r_any_seen     <= 1'b0;
            r_j_seen       <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_LOAD: begin
                    r_now          <= i_now_time;
                    r_ne           <= i_nonempty_mask & QMASK;
                    r_len          <= '0;
                    r_chosen       <= '0;
                    r_chosen_valid <= 1'b0;
                    r_chs_hit      <= 1'b0;
                end
                DP_SUM: begin
                    r_len <= r_len + SW'(w_dur);
                end
                DP_MOD_INIT: begin
                    r_rem <= '0;
                end
                DP_MOD_STEP: begin
                    // restoring division, one quotient bit a cycle
                    r_now <= {r_now[TW-2:0], 1'b0};
                    r_rem <= (w_rem_sh >= r_len) ? w_rem_sh - r_len : w_rem_sh;
                end
                DP_PASS_INIT: begin
                    r_off      <= '0;
                    r_lmt      <= r_len - r_rem;
                    r_chs_hit  <= 1'b0;
                    r_wait_hit <= 1'b0;
                    r_any_seen <= 1'b0;
                    r_j_seen   <= 1'b0;
                end
                DP_CHS: begin
                    r_off <= w_end;
                    if (w_cand_any) begin
                        if (r_rem < w_end) begin
                            r_chosen       <= w_cand_hi;
                            r_chosen_valid <= 1'b1;
                            r_chs_hit      <= 1'b1;
                        end else if (!r_chosen_valid) begin
                            r_chosen       <= w_cand_hi;
                            r_chosen_valid <= 1'b1;
                        end
                    end
                end
                DP_WAIT: begin
                    r_off <= w_end;
                    if (w_has_q[0]) begin
                        r_any_seen <= 1'b1;
                        if (r_rem < w_end) begin
                            if (w_t_stop < w_end) begin
                                r_wait_hit <= 1'b1;
                                r_open     <= w_open;
                            end else if (!r_any_seen && !r_j_seen) begin
                                r_wrap <= w_open;
                            end
                        end else if (!r_j_seen) begin
                            // first entry already passed in this cycle wins the wrap
                            r_j_seen <= 1'b1;
                            r_wrap   <= w_open;
                        end else if (!r_any_seen) begin
                            r_wrap <= w_open;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_FIN) begin
            o_queue_found  <= 1'b0;
            o_chosen_queue <= '0;
            o_dequeue_now  <= 1'b0;
            o_wait_time    <= '0;
            if (r_ne == '0) begin
                o_queue_found <= 1'b0;
            end else if (r_len == '0) begin
                o_queue_found  <= 1'b1;
                o_chosen_queue <= w_ne_lo;
                o_dequeue_now  <= 1'b1;
            end else if (r_chosen_valid) begin
                o_queue_found  <= 1'b1;
                o_chosen_queue <= r_chosen;
                if (r_wait_hit) begin
                    if (r_rem > r_open) begin
                        o_dequeue_now <= 1'b1;
                    end else begin
                        o_dequeue_now <= (r_open == r_rem);
                        o_wait_time   <= TW'(r_open - r_rem);
                    end
                end else begin
                    o_wait_time <= TW'(r_lmt + r_wrap);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tags_ctrl.sv =====
// ----------------------------------------------------------------------------
// tags_ctrl
// Controller: sequences the list walks and the modulo, owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tags_ctrl
    import tags_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_opcode  i_in_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire logic [4:0] i_active_entries,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_raddr
);

    localparam int AW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = $clog2(TW);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, w_used;
    logic [BW-1:0] r_bit, n_bit;
    logic          r_out_valid, n_out_valid;

    assign w_used = (32'(i_active_entries) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                          : CW'(i_active_entries);
    assign o_raddr     = r_cnt[AW-1:0];
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_op == OP_DECIDE) begin
                    o_cmd.op = DP_LOAD;
                    n_cnt    = '0;
                    n_state  = S_SUM_RD;
                end
            end
            S_SUM_RD: begin
                if (r_cnt == w_used) begin
                    o_cmd.op = DP_MOD_INIT;
                    n_bit    = '0;
                    n_state  = (i_stat.ne_zero || i_stat.len_zero) ? S_FIN : S_MOD;
                end else begin
                    n_state = S_SUM_EV;
                end
            end
            S_SUM_EV: begin
                o_cmd.op = DP_SUM;
                n_cnt    = r_cnt + 1'b1;
                n_state  = S_SUM_RD;
            end
            S_MOD: begin
                o_cmd.op = DP_MOD_STEP;
                n_bit    = r_bit + 1'b1;
                if (r_bit == BW'(TW - 1)) begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.op = DP_PASS_INIT;
                n_cnt    = '0;
                n_state  = S_CHS_RD;
            end
            S_CHS_RD: begin
                if (i_stat.chs_hit || r_cnt == w_used) begin
                    if (!i_stat.chosen_valid) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.op = DP_PASS_INIT;
                        n_cnt    = '0;
                        n_state  = S_WAIT_RD;
                    end
                end else begin
                    n_state = S_CHS_EV;
                end
            end
            S_CHS_EV: begin
                o_cmd.op = DP_CHS;
                n_cnt    = r_cnt + 1'b1;
                n_state  = S_CHS_RD;
            end
            S_WAIT_RD: begin
                n_state = (i_stat.wait_hit || r_cnt == w_used) ? S_FIN : S_WAIT_EV;
            end
            S_WAIT_EV: begin
                o_cmd.op = DP_WAIT;
                n_cnt    = r_cnt + 1'b1;
                n_state  = S_WAIT_RD;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_FIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/time_aware_gate_scheduler.sv =====
// ----------------------------------------------------------------------------
// time_aware_gate_scheduler
// Gate control list scheduler: picks the open non-empty queue and its wait.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  s_axis   in         tvalid/tready              tdata entry or decide, tuser opcode
//  m_axis   out        tvalid/tready              tdata decision
//  cfg      in         i_cfg_we                   i_cfg_wdata active entry count
//
//  A write item leaves the block idle and ready for the next item. A decide
//  item runs a sum walk over the list, a bit-serial modulo over the 48 time
//  bits, a pass setup, a choice walk and a wait walk over the single RAM read
//  port, then a result step that waits for a free output register. Each walk
//  reads an entry, then evaluates it. The choice and wait walks may stop early.
//  Reset is synchronous; the list RAM is not cleared.
//  A finished result sits in the output register while the next item enters.
// ----------------------------------------------------------------------------
`default_nettype none

module time_aware_gate_scheduler
    import tags_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // entry_index, entry_duration, entry_gate_mask, entry_start_guard,
    // entry_stop_guard, now_time, nonempty_mask, zero pad
    input  wire logic [167:0] i_s_axis_tdata,
    input  wire logic [0:0]   i_s_axis_tuser,   // opcode
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // queue_found, chosen_queue, dequeue_now, wait_time, zero pad
    output logic [55:0]       o_m_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    input  wire logic         i_cfg_we,
    input  wire logic [4:0]   i_cfg_wdata
);

    localparam int AW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;

    logic [4:0]         r_active;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [AW-1:0]      w_raddr;
    logic [ENTRY_W-1:0] w_rdata, w_wdata;
    logic               w_we, w_found, w_deq;
    logic [QW-1:0]      w_queue;
    logic [TW-1:0]      w_wait;
    t_opcode            w_op;

    assign w_op    = t_opcode'(i_s_axis_tuser[0]);
    assign w_we    = i_s_axis_tvalid && o_s_axis_tready && w_op == OP_WRITE &&
                     (32'(i_s_axis_tdata[3:0]) < MAX_ENTRIES);
    assign w_wdata = i_s_axis_tdata[107:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    tags_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_s_axis_tdata[3:0])),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tags_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_s_axis_tvalid),
        .i_in_op          (w_op),
        .o_in_ready       (o_s_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .i_active_entries (r_active),
        .i_stat           (w_stat),
        .o_cmd            (w_cmd),
        .o_raddr          (w_raddr)
    );

    tags_dp #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_now_time      (i_s_axis_tdata[155:108]),
        .i_nonempty_mask (i_s_axis_tdata[163:156]),
        .i_entry         (w_rdata),
        .o_queue_found   (w_found),
        .o_chosen_queue  (w_queue),
        .o_dequeue_now   (w_deq),
        .o_wait_time     (w_wait)
    );

    assign o_m_axis_tdata = {3'b000, w_wait, w_deq, w_queue, w_found};

    a_deq_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[4]) |-> (o_m_axis_tdata[52:5] == '0))
        else $error("dequeue_now with nonzero wait");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata == '0))
        else $error("no queue found but payload nonzero");

    a_decide_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0]) |=> !o_s_axis_tready)
        else $error("decide request did not start a walk");

endmodule

`default_nettype wire
